@@ design/fsp_pkg.sv @@
// Package for the FASTA record splitter: result kind codes, character codes,
// queue command type and queue sizing. No dependencies.
`timescale 1ns / 1ps

package fsp_pkg;

  // Result kind codes as seen on the output channel.
  localparam logic [2:0] KIND_HBYTE = 3'd0;
  localparam logic [2:0] KIND_HEND  = 3'd1;
  localparam logic [2:0] KIND_SBYTE = 3'd2;
  localparam logic [2:0] KIND_REND  = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  // Character codes.
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QueueDepth = 4;

  // Commands passed from the front to the back.
  typedef enum logic [2:0] {
    OP_HBYTE     = 3'd0,
    OP_HEND      = 3'd1,
    OP_SBYTE     = 3'd2,
    OP_REND      = 3'd3,
    OP_HEND_REND = 3'd4,
    OP_ERR       = 3'd5
  } fsp_op_e;

  typedef struct packed {
    fsp_op_e    op;
    logic [7:0] data;
  } fsp_cmd_t;

  // Whitespace test: space, TAB, LF, VT, FF and CR.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
           (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
  endfunction

endpackage

@@ design/fsp_in_if.sv @@
// Input channel of the FASTA record splitter: one text byte or an end mark.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps

interface fsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

@@ design/fsp_out_if.sv @@
// Output channel of the FASTA record splitter: one result item per transfer.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps

interface fsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [31:0] count;
  logic [31:0] record_index;

  modport source (output valid, kind, out_byte, count, record_index, input ready);
  modport sink   (input valid, kind, out_byte, count, record_index, output ready);
endinterface

@@ design/fsp_front.sv @@
// Front of the FASTA record splitter: accepts bytes, tracks the parse phase
// and pushes commands into the queue. Depends on fsp_pkg.
`timescale 1ns / 1ps

module fsp_front
  import fsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     [7:0] in_byte_i,
  input  logic     end_of_input_i,
  output logic     in_ready_o,
  input  logic     q_full_i,
  output logic     push_valid_o,
  output fsp_cmd_t push_cmd_o
);

  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_AFTGT = 6'b000010,
    PH_HEAD  = 6'b000100,
    PH_GAP   = 6'b001000,
    PH_SEQ   = 6'b010000,
    PH_ERROR = 6'b100000
  } fsp_phase_e;

  fsp_phase_e phase_q, phase_d;
  logic       accept;
  logic       push;
  fsp_op_e    op;

  // An item is taken whenever the queue has room.
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Phase transitions and command selection.
  always_comb begin
    phase_d = phase_q;
    push    = 1'b0;
    op      = OP_HBYTE;
    if (accept && phase_q != PH_ERROR) begin
      if (end_of_input_i) begin
        if (phase_q == PH_AFTGT || phase_q == PH_HEAD) begin
          push = 1'b1;
          op   = OP_HEND_REND;
        end else if (phase_q == PH_GAP || phase_q == PH_SEQ) begin
          push = 1'b1;
          op   = OP_REND;
        end
        phase_d = PH_START;
      end else begin
        unique case (phase_q)
          PH_START: begin
            if (!is_ws(in_byte_i)) begin
              if (in_byte_i == CHAR_GT) begin
                phase_d = PH_AFTGT;
              end else begin
                push    = 1'b1;
                op      = OP_ERR;
                phase_d = PH_ERROR;
              end
            end
          end
          PH_AFTGT, PH_HEAD: begin
            if (in_byte_i == CHAR_CR || in_byte_i == CHAR_LF) begin
              push    = 1'b1;
              op      = OP_HEND;
              phase_d = PH_GAP;
            end else if (!(phase_q == PH_AFTGT && is_ws(in_byte_i))) begin
              push    = 1'b1;
              op      = OP_HBYTE;
              phase_d = PH_HEAD;
            end
          end
          PH_GAP, PH_SEQ: begin
            if (in_byte_i == CHAR_GT) begin
              push    = 1'b1;
              op      = OP_REND;
              phase_d = PH_AFTGT;
            end else if (!is_ws(in_byte_i)) begin
              push    = 1'b1;
              op      = OP_SBYTE;
              phase_d = PH_SEQ;
            end
          end
          default: begin
            phase_d = PH_ERROR;
          end
        endcase
      end
    end
  end

  assign push_valid_o    = push;
  assign push_cmd_o.op   = op;
  assign push_cmd_o.data = in_byte_i;

  // Phase register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

@@ design/fsp_queue.sv @@
// Small command queue between the front and the back of the splitter.
// Flip-flop storage, first in first out. Depends on fsp_pkg.
`timescale 1ns / 1ps

module fsp_queue
  import fsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  fsp_cmd_t push_cmd_i,
  output logic     full_o,
  output logic     head_valid_o,
  output fsp_cmd_t head_cmd_o,
  input  logic     pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  fsp_cmd_t          mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     cnt_q;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == (PtrW+1)'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ design/fsp_back.sv @@
// Back of the FASTA record splitter: expands queued commands into result
// items, keeps the lengths and the record counter. Depends on fsp_pkg.
`timescale 1ns / 1ps

module fsp_back
  import fsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  fsp_cmd_t    head_cmd_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [31:0] count_o,
  output logic [31:0] record_index_o
);

  logic        out_valid_q;
  logic [2:0]  kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [31:0] count_q, count_d;
  logic [31:0] index_q;
  logic [31:0] hdr_len_q, hdr_len_d;
  logic [31:0] seq_len_q, seq_len_d;
  logic [31:0] rec_cnt_q, rec_cnt_d;
  logic        second_q, second_d;
  logic        load;

  // The output register takes a new result when empty or being drained.
  assign load  = head_valid_i && (!out_valid_q || out_ready_i);

  // Result selection and counter updates.
  always_comb begin
    kind_d    = KIND_HBYTE;
    byte_d    = '0;
    count_d   = '0;
    hdr_len_d = hdr_len_q;
    seq_len_d = seq_len_q;
    rec_cnt_d = rec_cnt_q;
    second_d  = second_q;
    pop_o     = 1'b0;
    if (load) begin
      pop_o    = 1'b1;
      second_d = 1'b0;
      unique case (head_cmd_i.op)
        OP_HBYTE: begin
          kind_d    = KIND_HBYTE;
          byte_d    = head_cmd_i.data;
          hdr_len_d = (hdr_len_q == '1) ? hdr_len_q : hdr_len_q + 1'b1;
        end
        OP_HEND: begin
          kind_d  = KIND_HEND;
          count_d = hdr_len_q;
        end
        OP_SBYTE: begin
          kind_d    = KIND_SBYTE;
          byte_d    = head_cmd_i.data;
          seq_len_d = (seq_len_q == '1) ? seq_len_q : seq_len_q + 1'b1;
        end
        OP_HEND_REND: begin
          if (!second_q) begin
            // First half: header end, the entry stays for the record end.
            kind_d   = KIND_HEND;
            count_d  = hdr_len_q;
            pop_o    = 1'b0;
            second_d = 1'b1;
          end else begin
            kind_d    = KIND_REND;
            count_d   = seq_len_q;
            rec_cnt_d = rec_cnt_q + 1'b1;
            hdr_len_d = '0;
            seq_len_d = '0;
          end
        end
        OP_REND: begin
          kind_d    = KIND_REND;
          count_d   = seq_len_q;
          rec_cnt_d = rec_cnt_q + 1'b1;
          hdr_len_d = '0;
          seq_len_d = '0;
        end
        OP_ERR: begin
          kind_d = KIND_ERR;
        end
        default: begin
          kind_d = KIND_ERR;
        end
      endcase
    end
  end

  // Control and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
      hdr_len_q   <= '0;
      seq_len_q   <= '0;
      rec_cnt_q   <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      second_q  <= second_d;
      hdr_len_q <= hdr_len_d;
      seq_len_q <= seq_len_d;
      rec_cnt_q <= rec_cnt_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      byte_q  <= byte_d;
      count_q <= count_d;
      index_q <= rec_cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign out_byte_o     = byte_q;
  assign count_o        = count_q;
  assign record_index_o = index_q;

endmodule

@@ design/fasta_record_splitter_unit.sv @@
// Top level of the FASTA record splitter: front, command queue and back.
// Depends on fsp_pkg, fsp_in_if, fsp_out_if, fsp_front, fsp_queue, fsp_back.
//
// Usage:
//   in_i carries one text byte per transfer, or an end-of-input mark that
//   closes the stream. out_o carries result items: header bytes, header end,
//   sequence bytes, record end (with saturating lengths and the record
//   index) and a single format error if the stream does not open with '>'.
//   A result is written into the command queue when its byte is taken and
//   then passes to the output register when the back loads it.
//   Throughput: one input byte per cycle while the queue has room; an end
//   mark inside a header yields two results, both from one queue entry.
//   The front classifies bytes and writes commands into a four-entry queue;
//   the back expands them into results through one output register. When
//   the receiver stalls the queue fills and in_i.ready falls once it is
//   full. After a format error every later byte is taken and dropped until
//   reset. Reset clears the phase, lengths, record counter and queue; no
//   clearing pass is needed.
`timescale 1ns / 1ps

module fasta_record_splitter_unit
  import fsp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  fsp_in_if.sink    in_i,
  fsp_out_if.source out_o
);

  logic     q_full;
  logic     push_valid;
  fsp_cmd_t push_cmd;
  logic     head_valid;
  fsp_cmd_t head_cmd;
  logic     pop;

  // Byte classification and phase tracking.
  fsp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_byte_i      (in_i.in_byte),
    .end_of_input_i (in_i.end_of_input),
    .in_ready_o     (in_i.ready),
    .q_full_i       (q_full),
    .push_valid_o   (push_valid),
    .push_cmd_o     (push_cmd)
  );

  // Command queue.
  fsp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  // Result generation.
  fsp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_cmd_i     (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .kind_o         (out_o.kind),
    .out_byte_o     (out_o.out_byte),
    .count_o        (out_o.count),
    .record_index_o (out_o.record_index)
  );

  // Only byte results carry a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind != KIND_HBYTE && out_o.kind != KIND_SBYTE)
      |-> (out_o.out_byte == 8'h00))
    else $error("non-byte result carries a byte");

  // Byte and error results carry no length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == KIND_HBYTE || out_o.kind == KIND_SBYTE ||
                     out_o.kind == KIND_ERR))
      |-> (out_o.count == 32'd0))
    else $error("byte or error result carries a length");

  // The format error is the last result until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.kind == KIND_ERR) |=> !out_o.valid)
    else $error("result after format error");

endmodule

@@ verif/tb_fasta_record_splitter_unit.sv @@
// Self-checking testbench for fasta_record_splitter_unit: a directed script, then random
// FASTA streams, with every result checked against a cycle-free parser model.
// Depends on fsp_pkg, fsp_in_if, fsp_out_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_fasta_record_splitter_unit;
  import fsp_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [31:0] count;
    logic [31:0] rec_idx;
  } fasta_result_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eoi;
  } text_item_t;

  typedef struct {
    logic [7:0]    c;
    logic          eoi;
    int            nfix;
    fasta_result_t r0;
    fasta_result_t r1;
  } script_row_t;

  typedef enum logic [2:0] {
    AWAIT_START, AFTER_GT, IN_HEADER, IN_GAP, IN_SEQUENCE, HALTED
  } parse_phase_e;

  localparam int PREDICT      = -1;
  localparam int OPEN_ROWS    = 28;
  localparam int SCRIPT_ROWS  = 33;
  localparam int RANDOM_ITEMS = 1100;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_LIMIT  = 5000;

  // Directed script. The rows before OPEN_ROWS run straight after reset; the rest
  // close the run, since a format error cannot be left again without a reset.
  script_row_t script [SCRIPT_ROWS] = '{
    '{8'h20, 1'b0, 0, '0, '0},
    '{8'hA5, 1'b1, 0, '0, '0},
    '{CHAR_GT, 1'b0, 0, '0, '0},
    '{CHAR_SPACE, 1'b0, 0, '0, '0},
    '{8'h00, 1'b0, 1, '{KIND_HBYTE, 8'h00, 32'd0, 32'd0}, '0},
    '{8'hFF, 1'b0, 1, '{KIND_HBYTE, 8'hFF, 32'd0, 32'd0}, '0},
    '{CHAR_LF, 1'b0, 1, '{KIND_HEND, 8'h00, 32'd2, 32'd0}, '0},
    '{CHAR_LF, 1'b0, 0, '0, '0},
    '{8'h21, 1'b0, PREDICT, '0, '0},
    '{8'hFF, 1'b0, 1, '{KIND_SBYTE, 8'hFF, 32'd0, 32'd0}, '0},
    '{CHAR_GT, 1'b0, 1, '{KIND_REND, 8'h00, 32'd2, 32'd0}, '0},
    '{CHAR_CR, 1'b0, 1, '{KIND_HEND, 8'h00, 32'd0, 32'd1}, '0},
    '{8'h41, 1'b0, PREDICT, '0, '0},
    '{8'h00, 1'b1, 1, '{KIND_REND, 8'h00, 32'd1, 32'd1}, '0},
    '{CHAR_GT, 1'b0, 0, '0, '0},
    '{8'h78, 1'b0, PREDICT, '0, '0},
    '{8'hFF, 1'b1, 2, '{KIND_HEND, 8'h00, 32'd1, 32'd2},
                      '{KIND_REND, 8'h00, 32'd0, 32'd2}},
    '{CHAR_TAB, 1'b0, 0, '0, '0},
    '{CHAR_GT, 1'b0, 0, '0, '0},
    '{8'h5A, 1'b1, 2, '{KIND_HEND, 8'h00, 32'd0, 32'd3},
                      '{KIND_REND, 8'h00, 32'd0, 32'd3}},
    '{CHAR_FF, 1'b0, 0, '0, '0},
    '{CHAR_GT, 1'b0, 0, '0, '0},
    '{CHAR_CR, 1'b0, 1, '{KIND_HEND, 8'h00, 32'd0, 32'd4}, '0},
    '{CHAR_VT, 1'b0, 0, '0, '0},
    '{CHAR_GT, 1'b0, 1, '{KIND_REND, 8'h00, 32'd0, 32'd4}, '0},
    '{CHAR_TAB, 1'b0, 0, '0, '0},
    '{CHAR_LF, 1'b0, 1, '{KIND_HEND, 8'h00, 32'd0, 32'd5}, '0},
    '{8'h00, 1'b1, 1, '{KIND_REND, 8'h00, 32'd0, 32'd5}, '0},
    '{CHAR_SPACE, 1'b0, 0, '0, '0},
    '{8'h4E, 1'b0, PREDICT, '0, '0},
    '{CHAR_GT, 1'b0, 0, '0, '0},
    '{8'h41, 1'b0, 0, '0, '0},
    '{8'h00, 1'b1, 0, '0, '0}
  };

  logic clk_i;
  logic rst_ni;

  fsp_in_if  in_ch ();
  fsp_out_if out_ch ();

  fasta_record_splitter_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Parser state mirrored by the testbench.
  parse_phase_e  phase_q;
  logic [31:0]   head_len_q;
  logic [31:0]   seq_len_q;
  logic [31:0]   rec_count_q;

  fasta_result_t split_results_q [$];
  text_item_t    stream_q [$];

  // Typed-in expectation of the script row currently offered, if any.
  int            fix_n;
  fasta_result_t fix_r0;
  fasta_result_t fix_r1;

  int mismatches;
  bit tx_calm;
  bit rx_calm;
  bit hold_req;

  function automatic logic blank_char(input logic [7:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF ||
           c == CHAR_VT || c == CHAR_FF || c == CHAR_CR;
  endfunction

  function automatic fasta_result_t make_result(input logic [2:0] k, input logic [7:0] d,
                                                input logic [31:0] cnt);
    return '{k, d, cnt, rec_count_q};
  endfunction

  // Advances the parser by one item and returns the number of results it gives.
  function automatic int parse_byte(input logic [7:0] c, input logic eoi,
                                    output fasta_result_t r0, output fasta_result_t r1);
    int n;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (phase_q != HALTED) begin
      if (eoi) begin
        if (phase_q == AFTER_GT || phase_q == IN_HEADER) begin
          r0 = make_result(KIND_HEND, 8'h00, head_len_q);
          r1 = make_result(KIND_REND, 8'h00, seq_len_q);
          n  = 2;
          rec_count_q = rec_count_q + 32'd1;
        end else if (phase_q == IN_GAP || phase_q == IN_SEQUENCE) begin
          r0 = make_result(KIND_REND, 8'h00, seq_len_q);
          n  = 1;
          rec_count_q = rec_count_q + 32'd1;
        end
        phase_q = AWAIT_START;
      end else begin
        case (phase_q)
          AWAIT_START: begin
            if (!blank_char(c)) begin
              if (c == CHAR_GT) begin
                head_len_q = '0;
                seq_len_q  = '0;
                phase_q    = AFTER_GT;
              end else begin
                r0 = make_result(KIND_ERR, 8'h00, 32'd0);
                n  = 1;
                phase_q = HALTED;
              end
            end
          end
          AFTER_GT, IN_HEADER: begin
            if (c == CHAR_CR || c == CHAR_LF) begin
              r0 = make_result(KIND_HEND, 8'h00, head_len_q);
              n  = 1;
              phase_q = IN_GAP;
            end else if (!(phase_q == AFTER_GT && blank_char(c))) begin
              r0 = make_result(KIND_HBYTE, c, 32'd0);
              n  = 1;
              head_len_q = (head_len_q == 32'hFFFF_FFFF) ? head_len_q : head_len_q + 32'd1;
              phase_q = IN_HEADER;
            end
          end
          IN_GAP, IN_SEQUENCE: begin
            if (c == CHAR_GT) begin
              r0 = make_result(KIND_REND, 8'h00, seq_len_q);
              n  = 1;
              rec_count_q = rec_count_q + 32'd1;
              head_len_q  = '0;
              seq_len_q   = '0;
              phase_q     = AFTER_GT;
            end else if (!blank_char(c)) begin
              r0 = make_result(KIND_SBYTE, c, 32'd0);
              n  = 1;
              seq_len_q = (seq_len_q == 32'hFFFF_FFFF) ? seq_len_q : seq_len_q + 32'd1;
              phase_q = IN_SEQUENCE;
            end
          end
          default: phase_q = HALTED;
        endcase
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] ws_char();
    case ($urandom_range(0, 5))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      2:       return CHAR_LF;
      3:       return CHAR_VT;
      4:       return CHAR_FF;
      default: return CHAR_CR;
    endcase
  endfunction

  // Builds one random stream of records, closed by an end mark. Some streams stop
  // early inside a header, some are empty, and headers and sequences are often short.
  task automatic build_stream();
    logic [7:0] c;
    int nrec;
    int len;
    stream_q.delete();
    repeat ($urandom_range(0, 2)) stream_q.push_back('{ws_char(), 1'b0});
    if ($urandom_range(0, 15) == 0) begin
      stream_q.push_back('{8'($urandom), 1'b1});
      return;
    end
    nrec = $urandom_range(1, 4);
    for (int r = 0; r < nrec; r++) begin
      stream_q.push_back('{CHAR_GT, 1'b0});
      repeat ($urandom_range(0, 2)) begin
        c = ($urandom_range(0, 1) == 0) ? CHAR_SPACE : CHAR_TAB;
        stream_q.push_back('{c, 1'b0});
      end
      len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
      repeat (len) begin
        do c = 8'($urandom); while (c == CHAR_CR || c == CHAR_LF);
        stream_q.push_back('{c, 1'b0});
      end
      case ($urandom_range(0, 9))
        0: begin
          stream_q.push_back('{8'($urandom), 1'b1});
          return;
        end
        1, 2, 3: stream_q.push_back('{CHAR_CR, 1'b0});
        4, 5, 6: stream_q.push_back('{CHAR_LF, 1'b0});
        default: begin
          stream_q.push_back('{CHAR_CR, 1'b0});
          stream_q.push_back('{CHAR_LF, 1'b0});
        end
      endcase
      repeat ($urandom_range(0, 2)) stream_q.push_back('{ws_char(), 1'b0});
      len = $urandom_range(0, 24);
      repeat (len) begin
        if ($urandom_range(0, 5) == 0) stream_q.push_back('{ws_char(), 1'b0});
        do c = 8'($urandom); while (blank_char(c) || c == CHAR_GT);
        stream_q.push_back('{c, 1'b0});
      end
      // Half the time the last sequence byte sits right against the next '>'.
      if ($urandom_range(0, 1) == 0) stream_q.push_back('{ws_char(), 1'b0});
    end
    stream_q.push_back('{8'($urandom), 1'b1});
  endtask

  // Offers one item after a random gap and returns at the falling edge after its transfer.
  task automatic send_item(input logic [7:0] c, input logic eoi, input int nfix,
                           input fasta_result_t r0, input fasta_result_t r1);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    fix_n  = nfix;
    fix_r0 = r0;
    fix_r1 = r1;
    in_ch.in_byte      <= c;
    in_ch.end_of_input <= eoi;
    in_ch.valid        <= 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Predict on every input transfer and check every output transfer.
  always @(posedge clk_i) begin : monitor
    fasta_result_t r0, r1, got, want;
    int n;
    if (rst_ni) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        n = parse_byte(in_ch.in_byte, in_ch.end_of_input, r0, r1);
        if (fix_n != PREDICT) begin
          n  = fix_n;
          r0 = fix_r0;
          r1 = fix_r1;
        end
        if (n > 0) split_results_q.push_back(r0);
        if (n > 1) split_results_q.push_back(r1);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.kind, out_ch.out_byte, out_ch.count, out_ch.record_index};
        if (split_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none awaited: kind %0d byte %02h count %0d %s %0d",
                     $realtime, got.kind, got.data, got.count, "record", got.rec_idx);
        end else begin
          want = split_results_q.pop_front();
          if (got.kind !== want.kind || got.data !== want.data ||
              got.count !== want.count || got.rec_idx !== want.rec_idx) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch kind %0d/%0d byte %02h/%02h count %0d/%0d ",
                        "record %0d/%0d (expected/actual)"},
                       $realtime, want.kind, got.kind, want.data, got.data,
                       want.count, got.count, want.rec_idx, got.rec_idx);
          end
        end
      end
    end
  end

  // Receiver: a random stall before each result, calm stretches, and one long hold.
  initial begin : receiver
    int stall;
    int served;
    out_ch.ready = 1'b0;
    served = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (served % 48 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 16);
      if (hold_req) begin
        stall    = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      served++;
      @(negedge clk_i);
    end
  end

  // Sender: reset, directed script, random streams, closing script, drain.
  initial begin : stimulus
    int sent;
    int drain;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'h00;
    in_ch.end_of_input = 1'b0;
    rst_ni      = 1'b0;
    mismatches  = 0;
    hold_req    = 1'b0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    fix_n       = PREDICT;
    fix_r0      = '0;
    fix_r1      = '0;
    phase_q     = AWAIT_START;
    head_len_q  = '0;
    seq_len_q   = '0;
    rec_count_q = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < OPEN_ROWS; i++)
      send_item(script[i].c, script[i].eoi, script[i].nfix, script[i].r0, script[i].r1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      build_stream();
      foreach (stream_q[k]) begin
        if (sent % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        // Hold the receiver off while items keep coming, so the queue fills up.
        if (sent == 300) begin
          hold_req = 1'b1;
          tx_calm  = 1'b1;
        end
        // Let the block drain completely before going on.
        if (sent == 700) begin
          in_ch.valid <= 1'b0;
          while (split_results_q.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
        end
        send_item(stream_q[k].c, stream_q[k].eoi, PREDICT, '0, '0);
        sent++;
      end
    end

    for (int i = OPEN_ROWS; i < SCRIPT_ROWS; i++)
      send_item(script[i].c, script[i].eoi, script[i].nfix, script[i].r0, script[i].r1);
    in_ch.valid <= 1'b0;

    drain = 0;
    while (split_results_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (split_results_q.size() != 0) begin
      $display("results never delivered: %0d", split_results_q.size());
      mismatches += split_results_q.size();
    end
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
